// File: src/dcmph_pkg.sv
// Package for the DC motor position controller with homing.
// Holds the opcode, register and homing phase codes, the shared structs and constants.
// No dependencies.
package dcmph_pkg;

   localparam logic [31:0] SETTLE_MS           = 32'd250;
   localparam logic [31:0] SWEEP_TARGET        = 32'd1000;
   localparam logic [31:0] AT_TARGET_TOLERANCE = 32'd2;
   localparam logic [14:0] LOAD_HIGH           = 15'h7FFF;
   localparam logic [7:0]  CMD_MAX             = 8'd255;

   localparam logic [15:0] GAIN_RESET       = 16'd256;
   localparam logic [7:0]  SLOW_LIMIT_RESET = 8'd64;
   localparam logic [7:0]  FAST_LIMIT_RESET = 8'd255;

   localparam int unsigned CSR_ADDR_WIDTH = 4;

   localparam logic [2:0] STEP_IDLE        = 3'd0;
   localparam logic [2:0] STEP_START       = 3'd1;
   localparam logic [2:0] STEP_SETTLE_FAST = 3'd2;
   localparam logic [2:0] STEP_SEEK_FAST   = 3'd3;
   localparam logic [2:0] STEP_SWEEP       = 3'd4;
   localparam logic [2:0] STEP_SETTLE_SLOW = 3'd5;
   localparam logic [2:0] STEP_SEEK_SLOW   = 3'd6;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_TARGET = 2'd1,
      OP_HOME   = 2'd2
   } dcmph_op_type;

   typedef enum logic [1:0] {
      REG_GAIN = 2'd0,
      REG_SLOW = 2'd1,
      REG_FAST = 2'd2
   } dcmph_reg_type;

   typedef enum logic [5:0] {
      PH_IDLE        = 6'b000001,
      PH_SETTLE_FAST = 6'b000010,
      PH_SEEK_FAST   = 6'b000100,
      PH_SWEEP       = 6'b001000,
      PH_SETTLE_SLOW = 6'b010000,
      PH_SEEK_SLOW   = 6'b100000
   } dcmph_phase_type;

   typedef struct packed {
      logic [15:0] gain_q8;
      logic [7:0]  slow_limit;
      logic [7:0]  fast_limit;
   } dcmph_cfg_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         opcode;
      logic signed [31:0] encoder_count;
      logic [31:0]        time_ms;
      logic signed [31:0] new_target;
   } dcmph_stage_type;

endpackage

// File: src/dcmph_if.sv
// Valid/ready channel interfaces for the request and response items.
// No dependencies.
interface dcmph_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [31:0] encoder_count;
   logic [31:0]        time_ms;
   logic signed [31:0] new_target;

   modport source (output valid, output opcode, output encoder_count, output time_ms,
                   output new_target, input ready);
   modport sink (input valid, input opcode, input encoder_count, input time_ms,
                 input new_target, output ready);
endinterface

interface dcmph_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pwm_duty;
   logic        drive_forward;
   logic        encoder_load;
   logic [14:0] encoder_load_value;
   logic [2:0]  homing_step;

   modport source (output valid, output pwm_duty, output drive_forward, output encoder_load,
                   output encoder_load_value, output homing_step, input ready);
   modport sink (input valid, input pwm_duty, input drive_forward, input encoder_load,
                 input encoder_load_value, input homing_step, output ready);
endinterface

// File: src/dcmph_csr.sv
// APB-style configuration registers: gain and the two speed limits.
// Depends on dcmph_pkg.
module dcmph_csr
   import dcmph_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready,
   output dcmph_cfg_type             cfg
);

   dcmph_cfg_type cfg_ff;
   dcmph_cfg_type cfg_in;
   logic          wr_en;
   logic [1:0]    reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_GAIN: cfg_in.gain_q8    = pwdata[15:0];
            REG_SLOW: cfg_in.slow_limit = pwdata[7:0];
            REG_FAST: cfg_in.fast_limit = pwdata[7:0];
            default:  cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_GAIN: prdata = {16'd0, cfg_ff.gain_q8};
         REG_SLOW: prdata = {24'd0, cfg_ff.slow_limit};
         REG_FAST: prdata = {24'd0, cfg_ff.fast_limit};
         default:  prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_q8    <= GAIN_RESET;
         cfg_ff.slow_limit <= SLOW_LIMIT_RESET;
         cfg_ff.fast_limit <= FAST_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: src/dcmph_in_stage.sv
// Input register stage: captures one request item and holds it until the controller takes it.
// Depends on dcmph_pkg and dcmph_req_if.
module dcmph_in_stage
   import dcmph_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   dcmph_req_if.sink       req,
   input  logic            stage_ready,
   output dcmph_stage_type stage
);

   logic            valid_ff;
   logic            valid_in;
   dcmph_stage_type item_ff;
   logic            take;

   assign req.ready = !valid_ff || stage_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (stage_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.valid         <= 1'b1;
         item_ff.opcode        <= req.opcode;
         item_ff.encoder_count <= req.encoder_count;
         item_ff.time_ms       <= req.time_ms;
         item_ff.new_target    <= req.new_target;
      end
   end

   always_comb begin
      stage       = item_ff;
      stage.valid = valid_ff;
   end

endmodule

// File: src/dcmph_ctrl.sv
// Controller state, proportional command, homing sequence and the response register.
// Depends on dcmph_pkg and dcmph_rsp_if.
module dcmph_ctrl
   import dcmph_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  dcmph_stage_type stage,
   input  dcmph_cfg_type   cfg,
   output logic            stage_ready,
   dcmph_rsp_if.source     rsp
);

   logic signed [31:0] position_ff, position_in;
   logic signed [31:0] target_ff, target_in;
   logic [7:0]         duty_ff, duty_in;
   logic               fwd_ff, fwd_in;
   logic [7:0]         limit_ff, limit_in;
   dcmph_phase_type    phase_ff, phase_in;
   logic [31:0]        timer_ff, timer_in;

   logic               rsp_valid_ff;
   logic [7:0]         rsp_duty_ff;
   logic               rsp_fwd_ff;
   logic               rsp_load_ff;
   logic [14:0]        rsp_load_value_ff;
   logic [2:0]         rsp_step_ff;

   logic               adv;
   logic signed [32:0] err;
   logic               err_neg;
   logic [32:0]        err_abs;
   logic [31:0]        mag;
   logic [47:0]        prod;
   logic [39:0]        prod_sh;
   logic [7:0]         sat;
   logic [7:0]         cmd_duty;
   logic               cmd_fwd;
   logic               at_target;
   logic               moved;
   logic [31:0]        elapsed;
   logic               load;
   logic               load_high;

   function automatic logic [2:0] step_of(dcmph_phase_type ph);
      logic [2:0] s;
      case (ph)
         PH_IDLE:        s = STEP_IDLE;
         PH_SETTLE_FAST: s = STEP_SETTLE_FAST;
         PH_SEEK_FAST:   s = STEP_SEEK_FAST;
         PH_SWEEP:       s = STEP_SWEEP;
         PH_SETTLE_SLOW: s = STEP_SETTLE_SLOW;
         PH_SEEK_SLOW:   s = STEP_SEEK_SLOW;
         default:        s = STEP_IDLE;
      endcase
      return s;
   endfunction

   assign stage_ready = !rsp_valid_ff || rsp.ready;
   assign adv         = stage.valid && stage_ready;

   // The error is taken against the new encoder count, which becomes the position on a tick.
   assign err     = {target_ff[31], target_ff} - {stage.encoder_count[31], stage.encoder_count};
   assign err_neg = err[32];
   assign err_abs = err_neg ? (~err + 33'd1) : err;
   assign mag     = err_abs[31:0];
   assign prod    = 48'(mag) * 48'(cfg.gain_q8);
   assign prod_sh = prod[47:8];
   assign sat     = (|prod_sh[39:8]) ? CMD_MAX : prod_sh[7:0];
   assign cmd_duty = (sat > limit_ff) ? limit_ff : sat;
   assign cmd_fwd  = !err_neg && (cmd_duty != 8'd0);
   assign at_target = (mag <= AT_TARGET_TOLERANCE);
   assign moved     = (stage.encoder_count != position_ff);
   assign elapsed   = stage.time_ms - timer_ff;

   always_comb begin
      position_in = position_ff;
      target_in   = target_ff;
      duty_in     = duty_ff;
      fwd_in      = fwd_ff;
      limit_in    = limit_ff;
      phase_in    = phase_ff;
      timer_in    = timer_ff;
      load        = 1'b0;
      load_high   = 1'b0;
      case (stage.opcode)
         OP_TICK: begin
            position_in = stage.encoder_count;
            duty_in     = cmd_duty;
            fwd_in      = cmd_fwd;
            case (phase_ff)
               PH_SETTLE_FAST, PH_SETTLE_SLOW: begin
                  if (elapsed >= SETTLE_MS) begin
                     phase_in = (phase_ff == PH_SETTLE_FAST) ? PH_SEEK_FAST : PH_SEEK_SLOW;
                     timer_in = stage.time_ms;
                  end
               end
               PH_SEEK_FAST: begin
                  if (moved) begin
                     timer_in = stage.time_ms;
                  end else if (elapsed > SETTLE_MS) begin
                     target_in = SWEEP_TARGET;
                     limit_in  = cfg.fast_limit;
                     phase_in  = PH_SWEEP;
                     load      = 1'b1;
                  end
               end
               PH_SEEK_SLOW: begin
                  if (moved) begin
                     timer_in = stage.time_ms;
                  end else if (elapsed > SETTLE_MS) begin
                     target_in = '0;
                     limit_in  = cfg.slow_limit;
                     phase_in  = PH_IDLE;
                     load      = 1'b1;
                  end
               end
               PH_SWEEP: begin
                  if (at_target) begin
                     target_in = '0;
                     limit_in  = cfg.slow_limit;
                     timer_in  = stage.time_ms;
                     phase_in  = PH_SETTLE_SLOW;
                     load      = 1'b1;
                     load_high = 1'b1;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         OP_TARGET: begin
            target_in = stage.new_target;
         end
         OP_HOME: begin
            limit_in  = cfg.fast_limit;
            target_in = '0;
            timer_in  = stage.time_ms;
            phase_in  = PH_SETTLE_FAST;
            load      = 1'b1;
            load_high = 1'b1;
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff  <= '0;
         target_ff    <= '0;
         duty_ff      <= '0;
         fwd_ff       <= 1'b0;
         limit_ff     <= FAST_LIMIT_RESET;
         phase_ff     <= PH_IDLE;
         timer_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            position_ff  <= position_in;
            target_ff    <= target_in;
            duty_ff      <= duty_in;
            fwd_ff       <= fwd_in;
            limit_ff     <= limit_in;
            phase_ff     <= phase_in;
            timer_ff     <= timer_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_duty_ff       <= duty_in;
         rsp_fwd_ff        <= fwd_in;
         rsp_load_ff       <= load;
         rsp_load_value_ff <= load_high ? LOAD_HIGH : 15'd0;
         rsp_step_ff       <= step_of(phase_in);
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.pwm_duty           = rsp_duty_ff;
   assign rsp.drive_forward      = rsp_fwd_ff;
   assign rsp.encoder_load       = rsp_load_ff;
   assign rsp.encoder_load_value = rsp_load_value_ff;
   assign rsp.homing_step        = rsp_step_ff;

   a_load_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_load_ff |-> rsp_load_value_ff == 15'd0)
      else $error("Load value shown without an encoder load.");

   a_fwd_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_fwd_ff |-> rsp_duty_ff != 8'd0)
      else $error("Forward drive with zero duty.");

   a_home_start: assert property (@(posedge clock) disable iff (reset)
      adv && stage.opcode == OP_HOME |=> phase_ff == PH_SETTLE_FAST && rsp_load_ff
      && rsp_load_value_ff == LOAD_HIGH)
      else $error("Homing start did not load the encoder and enter the fast settle phase.");

   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      adv && stage.opcode == OP_TICK |=> rsp_duty_ff <= $past(limit_ff))
      else $error("Drive duty exceeds the speed limit.");

endmodule

// File: src/dc_motor_position_homing.sv
// Top level of the DC motor position controller with homing.
// Depends on dcmph_pkg, dcmph_if, dcmph_csr, dcmph_in_stage and dcmph_ctrl.
//
// The block accepts one item per clock while the response side is not stalled and returns
// exactly one response item for each: an accepted item is held in the input register and
// then passes through the controller into the response register. The rate is set by the
// update of the controller state, whose longest path runs through the 33-bit error subtract,
// the 32x16 gain multiplier and the two clamps. Configuration registers take effect for items
// that reach the controller after the write; there is no clearing pass after reset.
module dc_motor_position_homing
   import dcmph_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   dcmph_req_if.sink                 req,
   dcmph_rsp_if.source               rsp,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   dcmph_cfg_type   cfg;
   dcmph_stage_type stage;
   logic            stage_ready;

   dcmph_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dcmph_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .stage_ready (stage_ready),
      .stage       (stage)
   );

   dcmph_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .stage       (stage),
      .cfg         (cfg),
      .stage_ready (stage_ready),
      .rsp         (rsp)
   );

endmodule

// File: tb/dc_motor_position_homing_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for dc_motor_position_homing: a mirror of the controller
// predicts every response item, while tasks drive ticks, targets and homing runs.
// Depends on dcmph_pkg, dcmph_if and the RTL of the block.
module dc_motor_position_homing_tb
   import dcmph_pkg::*;
();

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LIMIT_CYCLES = 500000;
   localparam int PHASE_ITEMS  = 200;
   localparam int HOLD_CYCLES  = 300;

   typedef struct packed {
      logic [7:0]  duty;
      logic        forward;
      logic        load;
      logic [14:0] load_value;
      logic [2:0]  step;
   } drive_out_type;

   class homing_ctrl_mirror_type;
      logic [15:0]        gain;
      logic [7:0]         slow_lim;
      logic [7:0]         fast_lim;
      logic signed [31:0] position;
      logic signed [31:0] last_delta;
      logic signed [31:0] target;
      logic signed [8:0]  drive_cmd;
      logic [7:0]         speed_lim;
      logic [2:0]         step;
      logic [31:0]        step_since;
      drive_out_type      pending_drive[$];
      int                 wrong_count;

      function new();
         gain = GAIN_RESET;
         slow_lim = SLOW_LIMIT_RESET;
         fast_lim = FAST_LIMIT_RESET;
         position = 0;
         last_delta = 0;
         target = 0;
         drive_cmd = 0;
         speed_lim = FAST_LIMIT_RESET;
         step = STEP_IDLE;
         step_since = 0;
         wrong_count = 0;
      endfunction

      function void flag(string what);
         wrong_count++;
         if (wrong_count <= 10) begin
            $display("[%0t] %s", $realtime, what);
         end
      endfunction

      function void set_register(dcmph_reg_type r, logic [31:0] v);
         case (r)
            REG_GAIN: gain = v[15:0];
            REG_SLOW: slow_lim = v[7:0];
            REG_FAST: fast_lim = v[7:0];
            default: ;
         endcase
      endfunction

      function longint error_now();
         return longint'(target) - longint'(position);
      endfunction

      function void recompute_drive();
         longint err, mag, prod, cmd, lim;
         err = error_now();
         mag = (err < 0) ? -err : err;
         prod = (mag * longint'(gain)) >>> 8;
         if (prod > 255) prod = 255;
         cmd = (err < 0) ? -prod : prod;
         lim = longint'(speed_lim);
         if (cmd > lim) cmd = lim;
         if (cmd < -lim) cmd = -lim;
         drive_cmd = 9'(cmd);
      endfunction

      function bit advance_homing(logic [31:0] now, logic [31:0] delta,
                                  output logic [14:0] load_val);
         logic [31:0] elapsed;
         longint      err;
         elapsed = now - step_since;
         load_val = '0;
         case (step)
            STEP_START: begin
               speed_lim = fast_lim;
               target = 0;
               step_since = now;
               step = STEP_SETTLE_FAST;
               load_val = LOAD_HIGH;
               return 1'b1;
            end
            STEP_SETTLE_FAST, STEP_SETTLE_SLOW: begin
               if (elapsed >= SETTLE_MS) begin
                  step = step + 3'd1;
                  step_since = now;
               end
            end
            STEP_SEEK_FAST, STEP_SEEK_SLOW: begin
               if (delta != 0) begin
                  step_since = now;
                  elapsed = 0;
               end
               if (elapsed > SETTLE_MS) begin
                  if (step == STEP_SEEK_FAST) begin
                     target = SWEEP_TARGET;
                     speed_lim = fast_lim;
                     step = STEP_SWEEP;
                  end else begin
                     target = 0;
                     speed_lim = slow_lim;
                     step = STEP_IDLE;
                  end
                  return 1'b1;
               end
            end
            STEP_SWEEP: begin
               err = error_now();
               if (err < 0) err = -err;
               if (err <= longint'(AT_TARGET_TOLERANCE)) begin
                  target = 0;
                  speed_lim = slow_lim;
                  step_since = now;
                  step = STEP_SETTLE_SLOW;
                  load_val = LOAD_HIGH;
                  return 1'b1;
               end
            end
            default: ;
         endcase
         return 1'b0;
      endfunction

      function void take_item(logic [1:0] op, logic signed [31:0] enc, logic [31:0] now,
                              logic signed [31:0] tgt);
         drive_out_type o;
         logic          load;
         logic [14:0]   lv;
         load = 1'b0;
         lv = '0;
         case (op)
            OP_TICK: begin
               last_delta = enc - position;
               position = enc;
               recompute_drive();
               if (step != STEP_IDLE) load = advance_homing(now, last_delta, lv);
            end
            OP_TARGET: target = tgt;
            OP_HOME: begin
               step = STEP_START;
               load = advance_homing(now, 32'd0, lv);
            end
            default: ;
         endcase
         o.duty = drive_cmd[8] ? 8'(-drive_cmd) : 8'(drive_cmd);
         o.forward = (drive_cmd > 0);
         o.load = load;
         o.load_value = load ? lv : 15'd0;
         o.step = step;
         pending_drive.push_back(o);
      endfunction

      function void compare_output(drive_out_type got);
         drive_out_type want;
         if (pending_drive.size() == 0) begin
            flag($sformatf("unexpected output item: duty %0d fwd %0d load %0d value %0d step %0d",
                           got.duty, got.forward, got.load, got.load_value, got.step));
         end else begin
            want = pending_drive.pop_front();
            if (want !== got) begin
               flag($sformatf({"wrong output: expected duty %0d fwd %0d load %0d value %0d ",
                               "step %0d, got duty %0d fwd %0d load %0d value %0d step %0d"},
                              want.duty, want.forward, want.load, want.load_value, want.step,
                              got.duty, got.forward, got.load, got.load_value, got.step));
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_WIDTH-1:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   dcmph_req_if req_ch();
   dcmph_rsp_if rsp_ch();

   dc_motor_position_homing dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   homing_ctrl_mirror_type mirror;
   bit                     quiet;
   bit                     hold_rsp;
   int                     items_sent;
   logic [31:0]            now_ms;
   logic signed [31:0]     shaft;
   logic signed [31:0]     aim;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("Mismatches found");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         mirror.compare_output({rsp_ch.pwm_duty, rsp_ch.drive_forward, rsp_ch.encoder_load,
                                rsp_ch.encoder_load_value, rsp_ch.homing_step});
      end
   end

   initial begin : receiver
      int stall;
      rsp_ch.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
      end
   end

   task automatic send_item(logic [1:0] op, logic [31:0] enc, logic [31:0] at_ms,
                            logic [31:0] tgt);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.encoder_count <= enc;
      req_ch.time_ms <= at_ms;
      req_ch.new_target <= tgt;
      do @(posedge clock); while (!req_ch.ready);
      mirror.take_item(op, enc, at_ms, tgt);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (mirror.pending_drive.size() != 0);
   endtask

   task automatic csr_access(dcmph_reg_type r, logic [31:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {r, 2'b00};
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      mirror.set_register(r, v);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== v) begin
         mirror.flag($sformatf("register %s read back %h, written %h", r.name(), prdata, v));
      end
   endtask

   task automatic program_registers(logic [15:0] g, logic [7:0] sl, logic [7:0] fl);
      csr_access(REG_GAIN, {16'd0, g});
      csr_access(REG_SLOW, {24'd0, sl});
      csr_access(REG_FAST, {24'd0, fl});
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic noise_item();
      case ($urandom_range(0, 2))
         0: begin
            aim = int'($urandom_range(0, 4000)) - 2000;
            send_item(OP_TARGET, $urandom(), now_ms, aim);
         end
         1: send_item(OP_HOME, $urandom(), now_ms, $urandom());
         default: send_item(OP_UNUSED, $urandom(), $urandom(), $urandom());
      endcase
   endtask

   task automatic homing_tick(int dt);
      if ($urandom_range(0, 24) == 0) noise_item();
      now_ms += dt;
      send_item(OP_TICK, shaft, now_ms, $urandom());
   endtask

   task automatic hold_still(int span_ms);
      int acc;
      int dt;
      acc = 0;
      while (acc < span_ms) begin
         dt = $urandom_range(10, 60);
         acc += dt;
         homing_tick(dt);
      end
   endtask

   task automatic run_homing();
      if ($urandom_range(0, 7) == 0) now_ms = 32'hFFFF_FFFF - $urandom_range(0, 900);
      send_item(OP_HOME, $urandom(), now_ms, $urandom());
      repeat ($urandom_range(0, 8)) begin
         shaft = shaft - int'($urandom_range(1, 60));
         homing_tick($urandom_range(5, 60));
      end
      hold_still($urandom_range(650, 900));
      repeat ($urandom_range(0, 4)) begin
         shaft = int'(SWEEP_TARGET) - int'($urandom_range(3, 500));
         homing_tick($urandom_range(5, 60));
      end
      if ($urandom_range(0, 3) == 0) begin
         shaft = int'(SWEEP_TARGET) + ($urandom_range(0, 1) ? 3 : -3);
         homing_tick($urandom_range(5, 60));
      end
      shaft = int'(SWEEP_TARGET) + int'($urandom_range(0, 4)) - 2;
      homing_tick($urandom_range(5, 60));
      repeat ($urandom_range(0, 6)) begin
         shaft = shaft - int'($urandom_range(1, 30));
         homing_tick($urandom_range(5, 60));
      end
      hold_still($urandom_range(650, 900));
   endtask

   task automatic random_burst(int n);
      int pick;
      repeat (n) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            case ($urandom_range(0, 3))
               0: shaft = $urandom();
               1: shaft = shaft + int'($urandom_range(0, 200)) - 100;
               2: begin
                  case ($urandom_range(0, 3))
                     0: shaft = 32'sh7FFF_FFFF;
                     1: shaft = 32'sh8000_0000;
                     2: shaft = 0;
                     default: shaft = -1;
                  endcase
               end
               default: shaft = aim + int'($urandom_range(0, 6)) - 3;
            endcase
            if ($urandom_range(0, 5) == 0) now_ms += $urandom();
            else now_ms += $urandom_range(0, 120);
            send_item(OP_TICK, shaft, now_ms, $urandom());
         end else if (pick < 8) begin
            case ($urandom_range(0, 2))
               0: aim = $urandom();
               1: aim = int'($urandom_range(0, 6000)) - 3000;
               default: aim = int'(SWEEP_TARGET) + int'($urandom_range(0, 10)) - 5;
            endcase
            send_item(OP_TARGET, $urandom(), now_ms, aim);
         end else if (pick == 8) begin
            send_item(OP_HOME, $urandom(), now_ms, $urandom());
         end else begin
            send_item(OP_UNUSED, $urandom(), $urandom(), $urandom());
         end
      end
   endtask

   initial begin : stimulus
      logic [31:0] t0;
      logic [15:0] gains[6];
      logic [7:0]  slows[6];
      logic [7:0]  fasts[6];
      int          budget;
      bit          held;
      mirror = new();
      quiet = 1'b0;
      hold_rsp = 1'b0;
      held = 1'b0;
      items_sent = 0;
      shaft = 0;
      aim = 0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_TICK;
      req_ch.encoder_count = '0;
      req_ch.time_ms = '0;
      req_ch.new_target = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      gains = '{GAIN_RESET, 16'd0, 16'hFFFF, 16'd1, 16'($urandom_range(16, 1024)),
                16'($urandom())};
      slows = '{SLOW_LIMIT_RESET, 8'd0, 8'd255, 8'd255, 8'($urandom()), 8'($urandom())};
      fasts = '{FAST_LIMIT_RESET, 8'd0, 8'd255, 8'd0, 8'($urandom()), 8'($urandom())};
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Saturated errors, the full 33-bit error range, and small errors of either sign.
      send_item(OP_TICK, 32'sh7FFF_FFFF, 32'd0, 32'd0);
      send_item(OP_TARGET, 32'd0, 32'd0, 32'sh8000_0000);
      send_item(OP_TICK, 32'sh7FFF_FFFF, 32'd1, 32'hFFFF_FFFF);
      send_item(OP_TARGET, 32'hFFFF_FFFF, 32'd2, 32'sh7FFF_FFFF);
      send_item(OP_TICK, 32'sh8000_0000, 32'd3, 32'd0);
      send_item(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_item(OP_TARGET, 32'd0, 32'd4, 32'd0);
      send_item(OP_TICK, -32'sd1, 32'd5, 32'd0);
      send_item(OP_TICK, 32'sd1, 32'd6, 32'd0);

      // A whole homing run across the time wrap, hitting each wait and stall boundary.
      t0 = 32'hFFFF_FE00;
      send_item(OP_HOME, 32'd0, t0, 32'd0);
      send_item(OP_TICK, -32'sd100, t0 + 32'd249, 32'd0);
      send_item(OP_TICK, -32'sd100, t0 + 32'd250, 32'd0);
      send_item(OP_TICK, -32'sd100, t0 + 32'd500, 32'd0);
      send_item(OP_TICK, -32'sd100, t0 + 32'd501, 32'd0);
      send_item(OP_TICK, 32'sd997, t0 + 32'd550, 32'd0);
      send_item(OP_TICK, 32'sd998, t0 + 32'd600, 32'd0);
      send_item(OP_TICK, 32'sd998, t0 + 32'd849, 32'd0);
      send_item(OP_TICK, 32'sd998, t0 + 32'd850, 32'd0);
      send_item(OP_TICK, 32'sd990, t0 + 32'd900, 32'd0);
      send_item(OP_TICK, 32'sd990, t0 + 32'd1150, 32'd0);
      send_item(OP_TICK, 32'sd990, t0 + 32'd1151, 32'd0);
      send_item(OP_HOME, 32'd0, t0 + 32'd1200, 32'd0);
      send_item(OP_HOME, 32'd0, t0 + 32'd1210, 32'd0);
      send_item(OP_TARGET, 32'd0, t0 + 32'd1220, 32'sd5);
      send_item(OP_TICK, 32'sd990, t0 + 32'd1230, 32'd0);
      now_ms = t0 + 32'd1230;
      shaft = 990;

      for (int p = 0; p < 6; p++) begin
         if (p > 0) begin
            wait_drained();
            program_registers(gains[p], slows[p], fasts[p]);
         end
         budget = items_sent + PHASE_ITEMS;
         while (items_sent < budget) begin
            quiet = ($urandom_range(0, 3) == 0);
            if (p == 2 && !held) begin
               held = 1'b1;
               quiet = 1'b1;
               hold_rsp = 1'b1;
               random_burst(60);
            end else if ($urandom_range(0, 9) < 6) begin
               run_homing();
            end else begin
               random_burst($urandom_range(10, 30));
            end
         end
      end

      quiet = 1'b0;
      wait_drained();
      repeat (10) @(posedge clock);
      if (mirror.wrong_count == 0 && mirror.pending_drive.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
